>>> sv/qrr_pkg.sv
// ----------------------------------------------------------------------------
// Quaternion ray rotate package
// Widths, register indexes, pipeline types and the saturation helper shared
// by the rotation datapath and the top level.
// ----------------------------------------------------------------------------
package qrr_pkg;

  // Coordinate format: signed, 16 fraction bits.
  localparam int CW  = 32;
  // Quaternion format: signed Q1.QFB.
  localparam int QFB = 30;
  localparam int QW  = QFB + 2;
  // Configuration data is as wide as the widest register.
  localparam int DW  = (QW > CW) ? QW : CW;

  // Offset origin - center and the sign-extended direction.
  localparam int VW  = CW + 1;
  // First Hamilton product: one term, the sum of terms, the rounded result.
  localparam int P1W = QW + VW;
  localparam int S1W = P1W + 2;
  localparam int TW  = S1W - QFB;
  // Second Hamilton product.
  localparam int P2W = TW + QW;
  localparam int S2W = P2W + 2;
  localparam int RW  = S2W - QFB;
  // Rotated component plus center, before saturation.
  localparam int OW  = RW + 1;

  // Terms per Hamilton product and vector components.
  localparam int NPROD = 12;
  localparam int NCOMP = 3;

  // Register stages from input to output register.
  localparam int PIPE_DEPTH = 6;

  localparam logic [QW-1:0] QUAT_ONE = QW'(1) << QFB;

  typedef enum logic [2:0] {
    CFG_QUAT_W   = 3'd0,
    CFG_QUAT_X   = 3'd1,
    CFG_QUAT_Y   = 3'd2,
    CFG_QUAT_Z   = 3'd3,
    CFG_CENTER_X = 3'd4,
    CFG_CENTER_Y = 3'd5,
    CFG_CENTER_Z = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [QW-1:0] w;
    logic [QW-1:0] x;
    logic [QW-1:0] y;
    logic [QW-1:0] z;
  } quat_t;

  // Load enables of the stages held inside the rotation datapath.
  typedef struct packed {
    logic prod1;
    logic sum1;
    logic prod2;
    logic sum2;
  } pipe_en_t;

  typedef struct packed {
    logic          ovf;
    logic [CW-1:0] val;
  } sat_t;

  // Clamp a wide signed value to the coordinate range.
  function automatic sat_t sat_coord(input logic signed [OW-1:0] v);
    sat_t res;
    logic fits;
    fits = (&v[OW-1:CW-1]) || !(|v[OW-1:CW-1]);
    res.ovf = !fits;
    if (fits) begin
      res.val = v[CW-1:0];
    end else if (v[OW-1]) begin
      res.val = {1'b1, {(CW-1){1'b0}}};
    end else begin
      res.val = {1'b0, {(CW-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

>>> sv/qrr_rotate.sv
// ----------------------------------------------------------------------------
// Quaternion rotation datapath
// Four register stages that rotate one vector as q * (0, v) * conj(q):
// terms of the first product, its rounded sums, terms of the second product,
// and its rounded vector part.
// ----------------------------------------------------------------------------
module qrr_rotate (
  input  logic                             clk_i,
  input  qrr_pkg::pipe_en_t                en_i,
  input  qrr_pkg::quat_t                   quat_i,
  input  logic signed [qrr_pkg::VW-1:0]    vec_i [qrr_pkg::NCOMP],
  output logic signed [qrr_pkg::RW-1:0]    rot_o [qrr_pkg::NCOMP]
);

  localparam logic signed [qrr_pkg::S1W-1:0] HALF1 = qrr_pkg::S1W'(1) << (qrr_pkg::QFB - 1);
  localparam logic signed [qrr_pkg::S2W-1:0] HALF2 = qrr_pkg::S2W'(1) << (qrr_pkg::QFB - 1);

  logic signed [qrr_pkg::QW-1:0]  qw, qx, qy, qz;
  logic signed [qrr_pkg::P1W-1:0] p1_q [qrr_pkg::NPROD];
  logic signed [qrr_pkg::S1W-1:0] s1   [4];
  logic signed [qrr_pkg::TW-1:0]  t_q  [4];
  logic signed [qrr_pkg::P2W-1:0] p2_q [qrr_pkg::NPROD];
  logic signed [qrr_pkg::S2W-1:0] s2   [qrr_pkg::NCOMP];
  logic signed [qrr_pkg::RW-1:0]  r_q  [qrr_pkg::NCOMP];

  assign qw = $signed(quat_i.w);
  assign qx = $signed(quat_i.x);
  assign qy = $signed(quat_i.y);
  assign qz = $signed(quat_i.z);

  // Terms of q * (0, v).
  always_ff @(posedge clk_i) begin
    if (en_i.prod1) begin
      p1_q[0]  <= qrr_pkg::P1W'(qx) * qrr_pkg::P1W'(vec_i[0]);
      p1_q[1]  <= qrr_pkg::P1W'(qy) * qrr_pkg::P1W'(vec_i[1]);
      p1_q[2]  <= qrr_pkg::P1W'(qz) * qrr_pkg::P1W'(vec_i[2]);
      p1_q[3]  <= qrr_pkg::P1W'(qw) * qrr_pkg::P1W'(vec_i[0]);
      p1_q[4]  <= qrr_pkg::P1W'(qy) * qrr_pkg::P1W'(vec_i[2]);
      p1_q[5]  <= qrr_pkg::P1W'(qz) * qrr_pkg::P1W'(vec_i[1]);
      p1_q[6]  <= qrr_pkg::P1W'(qw) * qrr_pkg::P1W'(vec_i[1]);
      p1_q[7]  <= qrr_pkg::P1W'(qx) * qrr_pkg::P1W'(vec_i[2]);
      p1_q[8]  <= qrr_pkg::P1W'(qz) * qrr_pkg::P1W'(vec_i[0]);
      p1_q[9]  <= qrr_pkg::P1W'(qw) * qrr_pkg::P1W'(vec_i[2]);
      p1_q[10] <= qrr_pkg::P1W'(qx) * qrr_pkg::P1W'(vec_i[1]);
      p1_q[11] <= qrr_pkg::P1W'(qy) * qrr_pkg::P1W'(vec_i[0]);
    end
  end

  // Exact sums, then round half up to the coordinate LSB.
  always_comb begin
    s1[0] = -qrr_pkg::S1W'(p1_q[0]) - qrr_pkg::S1W'(p1_q[1]) - qrr_pkg::S1W'(p1_q[2]) + HALF1;
    s1[1] =  qrr_pkg::S1W'(p1_q[3]) + qrr_pkg::S1W'(p1_q[4]) - qrr_pkg::S1W'(p1_q[5]) + HALF1;
    s1[2] =  qrr_pkg::S1W'(p1_q[6]) - qrr_pkg::S1W'(p1_q[7]) + qrr_pkg::S1W'(p1_q[8]) + HALF1;
    s1[3] =  qrr_pkg::S1W'(p1_q[9]) + qrr_pkg::S1W'(p1_q[10]) - qrr_pkg::S1W'(p1_q[11]) + HALF1;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sum1) begin
      for (int k = 0; k < 4; k++) begin
        t_q[k] <= s1[k][qrr_pkg::S1W-1:qrr_pkg::QFB];
      end
    end
  end

  // Terms of t * conj(q); t_q holds w, x, y, z in that order.
  always_ff @(posedge clk_i) begin
    if (en_i.prod2) begin
      p2_q[0]  <= qrr_pkg::P2W'(t_q[0]) * qrr_pkg::P2W'(qx);
      p2_q[1]  <= qrr_pkg::P2W'(t_q[0]) * qrr_pkg::P2W'(qy);
      p2_q[2]  <= qrr_pkg::P2W'(t_q[0]) * qrr_pkg::P2W'(qz);
      p2_q[3]  <= qrr_pkg::P2W'(t_q[1]) * qrr_pkg::P2W'(qw);
      p2_q[4]  <= qrr_pkg::P2W'(t_q[1]) * qrr_pkg::P2W'(qy);
      p2_q[5]  <= qrr_pkg::P2W'(t_q[1]) * qrr_pkg::P2W'(qz);
      p2_q[6]  <= qrr_pkg::P2W'(t_q[2]) * qrr_pkg::P2W'(qw);
      p2_q[7]  <= qrr_pkg::P2W'(t_q[2]) * qrr_pkg::P2W'(qx);
      p2_q[8]  <= qrr_pkg::P2W'(t_q[2]) * qrr_pkg::P2W'(qz);
      p2_q[9]  <= qrr_pkg::P2W'(t_q[3]) * qrr_pkg::P2W'(qw);
      p2_q[10] <= qrr_pkg::P2W'(t_q[3]) * qrr_pkg::P2W'(qx);
      p2_q[11] <= qrr_pkg::P2W'(t_q[3]) * qrr_pkg::P2W'(qy);
    end
  end

  always_comb begin
    s2[0] = -qrr_pkg::S2W'(p2_q[0]) + qrr_pkg::S2W'(p2_q[3]) - qrr_pkg::S2W'(p2_q[8])
            + qrr_pkg::S2W'(p2_q[11]) + HALF2;
    s2[1] = -qrr_pkg::S2W'(p2_q[1]) + qrr_pkg::S2W'(p2_q[5]) + qrr_pkg::S2W'(p2_q[6])
            - qrr_pkg::S2W'(p2_q[10]) + HALF2;
    s2[2] = -qrr_pkg::S2W'(p2_q[2]) - qrr_pkg::S2W'(p2_q[4]) + qrr_pkg::S2W'(p2_q[7])
            + qrr_pkg::S2W'(p2_q[9]) + HALF2;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sum2) begin
      for (int k = 0; k < qrr_pkg::NCOMP; k++) begin
        r_q[k] <= s2[k][qrr_pkg::S2W-1:qrr_pkg::QFB];
      end
    end
  end

  assign rot_o = r_q;

endmodule

>>> sv/quaternion_ray_rotate.sv
// ----------------------------------------------------------------------------
// Quaternion ray rotate
// Rotates each ray about a configured center by a configured quaternion.
//
// The block takes one ray beat every clock cycle while the output side does
// not stall. It has six register stages (offset, first product terms, first
// sums, second product terms, second sums, center add and saturation), and
// every stage holds its contents while the stage after it is full and
// stalled. The origin is rotated as an offset from center_x/y/z and the
// center is added back; the direction is rotated as is, so a plain vector
// rotation uses the direction fields alone. Quaternion registers are Q1.30
// and are used without normalization, so a non-unit quaternion scales the
// result by |q|^2. Coordinates are Q16.16; each product is rounded half up
// to the coordinate LSB, and every output saturates, with overflow_o
// flagging any clamp.
// Registers should be written only while no beat is in flight.
// ----------------------------------------------------------------------------
module quaternion_ray_rotate (
  input  logic                               clk_i,
  input  logic                               rst_ni,

  input  logic                               cfg_we_i,
  input  logic [2:0]                         cfg_idx_i,
  input  logic [qrr_pkg::DW-1:0]             cfg_wdata_i,

  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [qrr_pkg::CW-1:0]      origin_x_i,
  input  logic signed [qrr_pkg::CW-1:0]      origin_y_i,
  input  logic signed [qrr_pkg::CW-1:0]      origin_z_i,
  input  logic signed [qrr_pkg::CW-1:0]      dir_x_i,
  input  logic signed [qrr_pkg::CW-1:0]      dir_y_i,
  input  logic signed [qrr_pkg::CW-1:0]      dir_z_i,

  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [qrr_pkg::CW-1:0]      new_origin_x_o,
  output logic signed [qrr_pkg::CW-1:0]      new_origin_y_o,
  output logic signed [qrr_pkg::CW-1:0]      new_origin_z_o,
  output logic signed [qrr_pkg::CW-1:0]      new_dir_x_o,
  output logic signed [qrr_pkg::CW-1:0]      new_dir_y_o,
  output logic signed [qrr_pkg::CW-1:0]      new_dir_z_o,
  output logic                               overflow_o
);

  localparam int ND = qrr_pkg::PIPE_DEPTH;

  // Configuration registers.
  qrr_pkg::quat_t quat_q;
  logic signed [qrr_pkg::CW-1:0] center_q [qrr_pkg::NCOMP];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_q.w <= qrr_pkg::QUAT_ONE;
      quat_q.x <= '0;
      quat_q.y <= '0;
      quat_q.z <= '0;
      for (int k = 0; k < qrr_pkg::NCOMP; k++) begin
        center_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        qrr_pkg::CFG_QUAT_W:   quat_q.w    <= cfg_wdata_i[qrr_pkg::QW-1:0];
        qrr_pkg::CFG_QUAT_X:   quat_q.x    <= cfg_wdata_i[qrr_pkg::QW-1:0];
        qrr_pkg::CFG_QUAT_Y:   quat_q.y    <= cfg_wdata_i[qrr_pkg::QW-1:0];
        qrr_pkg::CFG_QUAT_Z:   quat_q.z    <= cfg_wdata_i[qrr_pkg::QW-1:0];
        qrr_pkg::CFG_CENTER_X: center_q[0] <= $signed(cfg_wdata_i[qrr_pkg::CW-1:0]);
        qrr_pkg::CFG_CENTER_Y: center_q[1] <= $signed(cfg_wdata_i[qrr_pkg::CW-1:0]);
        qrr_pkg::CFG_CENTER_Z: center_q[2] <= $signed(cfg_wdata_i[qrr_pkg::CW-1:0]);
        default: ;  // Writes beyond the register list are dropped.
      endcase
    end
  end

  // Pipeline control. A stage loads when it is empty or the stage after it
  // moves on, so bubbles collapse and a stall backs up without loss.
  logic [ND-1:0] vld_q, vld_d;
  logic [ND:0]   rdy;

  always_comb begin
    rdy[ND] = out_ready_i;
    for (int k = ND - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vld_d[0] = rdy[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < ND; k++) begin
      vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[ND-1];

  // Stage 1: the origin offset from the center and the direction, both
  // widened by one bit so the subtraction is exact.
  logic signed [qrr_pkg::VW-1:0] off_q [qrr_pkg::NCOMP];
  logic signed [qrr_pkg::VW-1:0] dir_q [qrr_pkg::NCOMP];

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      off_q[0] <= qrr_pkg::VW'(origin_x_i) - qrr_pkg::VW'(center_q[0]);
      off_q[1] <= qrr_pkg::VW'(origin_y_i) - qrr_pkg::VW'(center_q[1]);
      off_q[2] <= qrr_pkg::VW'(origin_z_i) - qrr_pkg::VW'(center_q[2]);
      dir_q[0] <= qrr_pkg::VW'(dir_x_i);
      dir_q[1] <= qrr_pkg::VW'(dir_y_i);
      dir_q[2] <= qrr_pkg::VW'(dir_z_i);
    end
  end

  // Stages 2 to 5: two identical rotation datapaths run side by side.
  qrr_pkg::pipe_en_t rot_en;
  logic signed [qrr_pkg::RW-1:0] rot_off [qrr_pkg::NCOMP];
  logic signed [qrr_pkg::RW-1:0] rot_dir [qrr_pkg::NCOMP];

  assign rot_en.prod1 = rdy[1];
  assign rot_en.sum1  = rdy[2];
  assign rot_en.prod2 = rdy[3];
  assign rot_en.sum2  = rdy[4];

  qrr_rotate u_rot_origin (
    .clk_i  (clk_i),
    .en_i   (rot_en),
    .quat_i (quat_q),
    .vec_i  (off_q),
    .rot_o  (rot_off)
  );

  qrr_rotate u_rot_dir (
    .clk_i  (clk_i),
    .en_i   (rot_en),
    .quat_i (quat_q),
    .vec_i  (dir_q),
    .rot_o  (rot_dir)
  );

  // Stage 6: add the center back to the origin, clamp all six components
  // and register the result beat.
  qrr_pkg::sat_t sat_org [qrr_pkg::NCOMP];
  qrr_pkg::sat_t sat_dir [qrr_pkg::NCOMP];
  logic [qrr_pkg::CW-1:0] org_q [qrr_pkg::NCOMP];
  logic [qrr_pkg::CW-1:0] nd_q  [qrr_pkg::NCOMP];
  logic                   ovf_q;

  always_comb begin
    for (int k = 0; k < qrr_pkg::NCOMP; k++) begin
      sat_org[k] = qrr_pkg::sat_coord(qrr_pkg::OW'(rot_off[k]) + qrr_pkg::OW'(center_q[k]));
      sat_dir[k] = qrr_pkg::sat_coord(qrr_pkg::OW'(rot_dir[k]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      for (int k = 0; k < qrr_pkg::NCOMP; k++) begin
        org_q[k] <= sat_org[k].val;
        nd_q[k]  <= sat_dir[k].val;
      end
      ovf_q <= sat_org[0].ovf || sat_org[1].ovf || sat_org[2].ovf ||
               sat_dir[0].ovf || sat_dir[1].ovf || sat_dir[2].ovf;
    end
  end

  assign new_origin_x_o = $signed(org_q[0]);
  assign new_origin_y_o = $signed(org_q[1]);
  assign new_origin_z_o = $signed(org_q[2]);
  assign new_dir_x_o    = $signed(nd_q[0]);
  assign new_dir_y_o    = $signed(nd_q[1]);
  assign new_dir_z_o    = $signed(nd_q[2]);
  assign overflow_o     = ovf_q;

  // The pipeline never holds off input while the output side is taking beats.
  a_no_stall_when_drained : assert property (
    @(posedge clk_i) disable iff (!rst_ni) out_ready_i |-> in_ready_o
  ) else $error("input stalled although the output is ready");

  // A completely full pipeline with a stalled output must refuse new beats.
  a_full_backpressure : assert property (
    @(posedge clk_i) disable iff (!rst_ni) ((&vld_q) && !out_ready_i) |-> !in_ready_o
  ) else $error("input accepted into a full, stalled pipeline");

  // The overflow flag only comes with at least one clamped component.
  a_overflow_clamped : assert property (
    @(posedge clk_i) disable iff (!rst_ni) (out_valid_o && overflow_o) |->
      (new_origin_x_o == {1'b1, {(qrr_pkg::CW-1){1'b0}}} ||
       new_origin_x_o == {1'b0, {(qrr_pkg::CW-1){1'b1}}} ||
       new_origin_y_o == {1'b1, {(qrr_pkg::CW-1){1'b0}}} ||
       new_origin_y_o == {1'b0, {(qrr_pkg::CW-1){1'b1}}} ||
       new_origin_z_o == {1'b1, {(qrr_pkg::CW-1){1'b0}}} ||
       new_origin_z_o == {1'b0, {(qrr_pkg::CW-1){1'b1}}} ||
       new_dir_x_o    == {1'b1, {(qrr_pkg::CW-1){1'b0}}} ||
       new_dir_x_o    == {1'b0, {(qrr_pkg::CW-1){1'b1}}} ||
       new_dir_y_o    == {1'b1, {(qrr_pkg::CW-1){1'b0}}} ||
       new_dir_y_o    == {1'b0, {(qrr_pkg::CW-1){1'b1}}} ||
       new_dir_z_o    == {1'b1, {(qrr_pkg::CW-1){1'b0}}} ||
       new_dir_z_o    == {1'b0, {(qrr_pkg::CW-1){1'b1}}})
  ) else $error("overflow flagged without a saturated component");

endmodule

>>> tb/sv/qrr_rotation_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Quaternion ray rotate checker
// Mirrors the register writes, predicts the rotated ray for every accepted
// input beat and compares each accepted result beat against it in order.
// ----------------------------------------------------------------------------
module qrr_rotation_checker
  import qrr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [DW-1:0]        cfg_wdata_i,

  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic signed [CW-1:0] origin_x_i,
  input  logic signed [CW-1:0] origin_y_i,
  input  logic signed [CW-1:0] origin_z_i,
  input  logic signed [CW-1:0] dir_x_i,
  input  logic signed [CW-1:0] dir_y_i,
  input  logic signed [CW-1:0] dir_z_i,

  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic signed [CW-1:0] new_origin_x_i,
  input  logic signed [CW-1:0] new_origin_y_i,
  input  logic signed [CW-1:0] new_origin_z_i,
  input  logic signed [CW-1:0] new_dir_x_i,
  input  logic signed [CW-1:0] new_dir_y_i,
  input  logic signed [CW-1:0] new_dir_z_i,
  input  logic                 overflow_i,

  output int                   fail_cnt_o,
  output int                   pending_o
);

  // Wide enough to hold every product sum exactly.
  typedef logic signed [127:0] acc_t;

  typedef struct packed {
    logic [CW-1:0] org_x;
    logic [CW-1:0] org_y;
    logic [CW-1:0] org_z;
    logic [CW-1:0] dir_x;
    logic [CW-1:0] dir_y;
    logic [CW-1:0] dir_z;
    logic          ovf;
  } rotated_ray_t;

  quat_t                quat_q;
  logic signed [CW-1:0] center_q [3];
  rotated_ray_t         rotated_q [$];
  int                   mismatches = 0;

  assign fail_cnt_o = mismatches;

  // Round half up to the coordinate LSB.
  function automatic acc_t round_to_coord(input acc_t sum);
    acc_t biased;
    biased = sum + (acc_t'(1) <<< (QFB - 1));
    return biased >>> QFB;
  endfunction

  function automatic logic [CW-1:0] clamp_coord(input acc_t v, inout logic ovf);
    acc_t hi, lo;
    hi = (acc_t'(1) <<< (CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      ovf = 1'b1;
      return hi[CW-1:0];
    end else if (v < lo) begin
      ovf = 1'b1;
      return lo[CW-1:0];
    end
    return v[CW-1:0];
  endfunction

  // q * (0, v) * conj(q), each Hamilton product rounded on its own.
  function automatic void rotate_by_quat(input acc_t vx, vy, vz,
                                         output acc_t rx, ry, rz);
    acc_t w, x, y, z, tw, tx, ty, tz;
    w = $signed(quat_q.w);
    x = $signed(quat_q.x);
    y = $signed(quat_q.y);
    z = $signed(quat_q.z);
    tw = round_to_coord(-x * vx - y * vy - z * vz);
    tx = round_to_coord(w * vx + y * vz - z * vy);
    ty = round_to_coord(w * vy - x * vz + z * vx);
    tz = round_to_coord(w * vz + x * vy - y * vx);
    rx = round_to_coord(-tw * x + tx * w - ty * z + tz * y);
    ry = round_to_coord(-tw * y + tx * z + ty * w - tz * x);
    rz = round_to_coord(-tw * z - tx * y + ty * x + tz * w);
  endfunction

  function automatic rotated_ray_t predict_rotation(
    input logic signed [CW-1:0] org_x, org_y, org_z, dx, dy, dz);
    acc_t ro_x, ro_y, ro_z, rd_x, rd_y, rd_z;
    rotated_ray_t res;
    logic ovf;
    ovf = 1'b0;
    rotate_by_quat(acc_t'(org_x) - acc_t'(center_q[0]),
                   acc_t'(org_y) - acc_t'(center_q[1]),
                   acc_t'(org_z) - acc_t'(center_q[2]), ro_x, ro_y, ro_z);
    rotate_by_quat(acc_t'(dx), acc_t'(dy), acc_t'(dz), rd_x, rd_y, rd_z);
    res.org_x = clamp_coord(ro_x + acc_t'(center_q[0]), ovf);
    res.org_y = clamp_coord(ro_y + acc_t'(center_q[1]), ovf);
    res.org_z = clamp_coord(ro_z + acc_t'(center_q[2]), ovf);
    res.dir_x = clamp_coord(rd_x, ovf);
    res.dir_y = clamp_coord(rd_y, ovf);
    res.dir_z = clamp_coord(rd_z, ovf);
    res.ovf   = ovf;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [CW-1:0] want, got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rotated_ray_t want;
    if (!rst_ni) begin
      quat_q.w = QUAT_ONE;
      quat_q.x = '0;
      quat_q.y = '0;
      quat_q.z = '0;
      for (int i = 0; i < 3; i++) center_q[i] = '0;
      rotated_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_QUAT_W:   quat_q.w    = cfg_wdata_i[QW-1:0];
          CFG_QUAT_X:   quat_q.x    = cfg_wdata_i[QW-1:0];
          CFG_QUAT_Y:   quat_q.y    = cfg_wdata_i[QW-1:0];
          CFG_QUAT_Z:   quat_q.z    = cfg_wdata_i[QW-1:0];
          CFG_CENTER_X: center_q[0] = cfg_wdata_i[CW-1:0];
          CFG_CENTER_Y: center_q[1] = cfg_wdata_i[CW-1:0];
          CFG_CENTER_Z: center_q[2] = cfg_wdata_i[CW-1:0];
          default: ;  // An index without a register drops the write.
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (rotated_q.size() == 0) begin
          $display("%0t: result beat with no ray outstanding, new_dir_x %h",
                   $time, new_dir_x_i);
          mismatches++;
        end else begin
          want = rotated_q.pop_front();
          check_field("new_origin_x", want.org_x, new_origin_x_i);
          check_field("new_origin_y", want.org_y, new_origin_y_i);
          check_field("new_origin_z", want.org_z, new_origin_z_i);
          check_field("new_dir_x", want.dir_x, new_dir_x_i);
          check_field("new_dir_y", want.dir_y, new_dir_y_i);
          check_field("new_dir_z", want.dir_z, new_dir_z_i);
          check_field("overflow", CW'(want.ovf), CW'(overflow_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        rotated_q.push_back(predict_rotation(origin_x_i, origin_y_i, origin_z_i,
                                             dir_x_i, dir_y_i, dir_z_i));
      end
      pending_o <= rotated_q.size();
    end
  end

endmodule

>>> tb/sv/tb_quaternion_ray_rotate.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Quaternion ray rotate testbench
// Drives rays into the rotator under a series of quaternion and center
// settings, with random stalls on both handshakes, and lets the checker
// compare every result beat against its own fixed-point prediction.
// ----------------------------------------------------------------------------
module tb_quaternion_ray_rotate;
  import qrr_pkg::*;

  // Index 7 has no register behind it; writes there must change nothing.
  localparam logic [2:0]    CFG_IDX_UNUSED = 3'd7;

  localparam int            RANDOM_RAYS = 1150;
  localparam int            PHASES      = 10;

  // Handy quaternion components in Q1.30.
  localparam logic [31:0]   Q_NEG_ONE = 32'hC000_0000;
  localparam logic [31:0]   Q_HALF    = 32'h2000_0000;
  localparam logic [31:0]   Q_RSQRT2  = 32'd759250125;
  // Register bit patterns beyond the nominal quaternion range.
  localparam logic [31:0]   Q_BITS_MIN = 32'h8000_0000;
  localparam logic [31:0]   Q_BITS_MAX = 32'h7FFF_FFFF;

  // Q16.16 coordinate extremes.
  localparam logic [CW-1:0] C_MAX  = 32'h7FFF_FFFF;
  localparam logic [CW-1:0] C_MIN  = 32'h8000_0000;
  localparam logic [CW-1:0] C_UNIT = 32'h0001_0000;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 cfg_we_i       = 1'b0;
  logic [2:0]           cfg_idx_i      = '0;
  logic [DW-1:0]        cfg_wdata_i    = '0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_ready_o;
  logic signed [CW-1:0] origin_x_i     = '0;
  logic signed [CW-1:0] origin_y_i     = '0;
  logic signed [CW-1:0] origin_z_i     = '0;
  logic signed [CW-1:0] dir_x_i        = '0;
  logic signed [CW-1:0] dir_y_i        = '0;
  logic signed [CW-1:0] dir_z_i        = '0;
  logic                 out_valid_o;
  logic                 out_ready_i    = 1'b0;
  logic signed [CW-1:0] new_origin_x_o;
  logic signed [CW-1:0] new_origin_y_o;
  logic signed [CW-1:0] new_origin_z_o;
  logic signed [CW-1:0] new_dir_x_o;
  logic signed [CW-1:0] new_dir_y_o;
  logic signed [CW-1:0] new_dir_z_o;
  logic                 overflow_o;

  int                   fail_cnt;
  int                   rays_in_flight;

  // When clear, neither the ray source nor the result sink inserts gaps.
  bit                   idle_en = 1'b1;

  quaternion_ray_rotate u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .origin_x_i     (origin_x_i),
    .origin_y_i     (origin_y_i),
    .origin_z_i     (origin_z_i),
    .dir_x_i        (dir_x_i),
    .dir_y_i        (dir_y_i),
    .dir_z_i        (dir_z_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .new_origin_x_o (new_origin_x_o),
    .new_origin_y_o (new_origin_y_o),
    .new_origin_z_o (new_origin_z_o),
    .new_dir_x_o    (new_dir_x_o),
    .new_dir_y_o    (new_dir_y_o),
    .new_dir_z_o    (new_dir_z_o),
    .overflow_o     (overflow_o)
  );

  qrr_rotation_checker u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .origin_x_i     (origin_x_i),
    .origin_y_i     (origin_y_i),
    .origin_z_i     (origin_z_i),
    .dir_x_i        (dir_x_i),
    .dir_y_i        (dir_y_i),
    .dir_z_i        (dir_z_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .new_origin_x_i (new_origin_x_o),
    .new_origin_y_i (new_origin_y_o),
    .new_origin_z_i (new_origin_z_o),
    .new_dir_x_i    (new_dir_x_o),
    .new_dir_y_i    (new_dir_y_o),
    .new_dir_z_i    (new_dir_z_o),
    .overflow_i     (overflow_o),
    .fail_cnt_o     (fail_cnt),
    .pending_o      (rays_in_flight)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a correct run with the worst stalls needs well under a tenth
  // of this, so reaching it means the block hung or dropped results.
  initial begin
    #5_000_000;
    $display("quaternion_ray_rotate test failed");
    $finish;
  end

  // Result sink. Ready is mostly high; while idling is enabled it drops
  // low now and then for a random burst.
  initial begin
    forever begin
      @(posedge clk_i);
      if (idle_en && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  function automatic logic [31:0] with_rand_sign(input logic [31:0] mag);
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  // Coordinates are mostly modest so that rotations usually stay in range,
  // with full-range words and the extremes mixed in to drive saturation.
  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
      6, 7:             return $urandom();
      8: begin
        case ($urandom_range(0, 3))
          0:       return C_MAX;
          1:       return C_MIN;
          2:       return '0;
          default: return '1;
        endcase
      end
      default:          return $urandom_range(0, 32'h1FFF_FFFF) - 32'h1000_0000;
    endcase
  endfunction

  // One register write per call; the enable stays high across back-to-back
  // calls and is dropped by cfg_close.
  task automatic cfg_write(input logic [2:0] idx, input logic [DW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
  endtask

  task automatic cfg_close();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_config(input logic [31:0] qw, qx, qy, qz, cx, cy, cz,
                             input bit poke_unused);
    cfg_write(CFG_QUAT_W, qw);
    cfg_write(CFG_QUAT_X, qx);
    cfg_write(CFG_QUAT_Y, qy);
    cfg_write(CFG_QUAT_Z, qz);
    cfg_write(CFG_CENTER_X, cx);
    cfg_write(CFG_CENTER_Y, cy);
    cfg_write(CFG_CENTER_Z, cz);
    if (poke_unused) cfg_write(CFG_IDX_UNUSED, $urandom());
    cfg_close();
  endtask

  // Offers one ray and returns at the edge that accepts it. Valid stays
  // high into the next ray unless a gap is drawn.
  task automatic send_ray(input logic [CW-1:0] ox, oy, oz, dx, dy, dz);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    origin_x_i <= ox;
    origin_y_i <= oy;
    origin_z_i <= oz;
    dir_x_i    <= dx;
    dir_y_i    <= dy;
    dir_z_i    <= dz;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Holds the source off until every predicted result has been returned.
  // The first edge lets the count pick up a beat accepted just before.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (rays_in_flight != 0) @(posedge clk_i);
  endtask

  // Rays at the corners of the coordinate range.
  task automatic send_corner_rays();
    send_ray(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
    send_ray(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
    send_ray(C_MAX, C_MIN, '0, C_MIN, C_MAX, C_UNIT);
  endtask

  initial begin
    logic [31:0] quat_set [4];
    logic [31:0] center_set [3];
    int a, b;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. The reset setting is the identity about the origin, so
    // even the corner rays must come back untouched.
    send_ray('0, '0, '0, '0, '0, '0);
    send_corner_rays();

    // Every component at +1.0 gives |q|^2 = 4, and the centers sit at the
    // top of the range: a non-unit quaternion that saturates heavily.
    drain();
    load_config(QUAT_ONE, QUAT_ONE, QUAT_ONE, QUAT_ONE, C_MAX, C_MAX, C_MAX, 1'b0);
    send_corner_rays();

    // q = -1 is still the identity rotation; the centers at the bottom make
    // the origin offsets reach 33 bits.
    drain();
    load_config(Q_NEG_ONE, '0, '0, '0, C_MIN, C_MIN, C_MIN, 1'b0);
    send_corner_rays();

    // Register patterns outside the nominal quaternion range are used as
    // they stand. A write to the unused index follows and must be ignored.
    drain();
    load_config(Q_BITS_MIN, Q_BITS_MAX, Q_BITS_MIN, Q_BITS_MAX, C_MAX, C_MIN, '0, 1'b1);
    send_corner_rays();

    // Half-turn about x around an off-origin center.
    drain();
    load_config('0, QUAT_ONE, '0, '0, C_UNIT, -C_UNIT, 32'h0003_8000, 1'b0);
    send_corner_rays();

    // Third of a turn about the (1,1,1) diagonal, which permutes the axes.
    drain();
    load_config(Q_HALF, Q_HALF, Q_HALF, Q_HALF, '0, '0, '0, 1'b0);
    send_corner_rays();

    // Random part: each phase loads a fresh setting, mostly unit rotations
    // or quaternions inside the unit ball, and streams random rays through.
    // Every third phase and the last one run without gaps on either side.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      idle_en = (ph % 3 != 2) && (ph != PHASES - 1);
      for (int k = 0; k < 4; k++) quat_set[k] = '0;
      case ($urandom_range(0, 7))
        0, 1: quat_set[$urandom_range(0, 3)] = with_rand_sign(QUAT_ONE);
        2: begin
          a = $urandom_range(0, 3);
          b = (a + $urandom_range(1, 3)) % 4;
          quat_set[a] = with_rand_sign(Q_RSQRT2);
          quat_set[b] = with_rand_sign(Q_RSQRT2);
        end
        3: for (int k = 0; k < 4; k++) quat_set[k] = with_rand_sign(Q_HALF);
        4, 5: begin
          for (int k = 0; k < 4; k++) begin
            quat_set[k] = $urandom_range(0, 32'h4000_0000) - Q_HALF;
          end
        end
        6: begin
          for (int k = 0; k < 4; k++) begin
            quat_set[k] = $urandom_range(0, 32'h8000_0000) - QUAT_ONE;
          end
        end
        default: for (int k = 0; k < 4; k++) quat_set[k] = $urandom();
      endcase
      for (int k = 0; k < 3; k++) begin
        if ($urandom_range(0, 4) == 0) begin
          center_set[k] = $urandom();
        end else begin
          center_set[k] = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
        end
      end
      load_config(quat_set[0], quat_set[1], quat_set[2], quat_set[3],
                  center_set[0], center_set[1], center_set[2],
                  $urandom_range(0, 2) == 0);
      for (int n = 0; n < RANDOM_RAYS / PHASES; n++) begin
        // Occasionally let the pipeline empty out in the middle of a phase.
        if (n > 0 && $urandom_range(0, 199) == 0) drain();
        send_ray(rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord(), rand_coord());
      end
    end

    // Wait out the last results, then keep watching the output so that any
    // stray result beat is still caught.
    drain();
    repeat (4 * PIPE_DEPTH) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("quaternion_ray_rotate test passed");
    end else begin
      $display("quaternion_ray_rotate test failed");
    end
    $finish;
  end

endmodule
